### rtl/dia_pkg.sv
// Package for the descriptor index allocator.
// Holds field widths, register defaults, codes, controller states and the
// command and status structs shared by the controller and the datapath.
package dia_pkg;

   localparam int IDX_W        = 10;
   localparam int MODE_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 11;
   localparam int STRIDE_W     = 16;
   localparam int ADDR_W       = 64;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 64;
   localparam int OFFSET_W     = STRIDE_W + IDX_W;

   localparam int SLOT_DEPTH_DEFAULT = 1024;

   localparam logic [COUNT_W-1:0]  SLOT_COUNT_RESET  = COUNT_W'(1024);
   localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RESET = STRIDE_W'(32);
   localparam logic [ADDR_W-1:0]   CPU_BASE_RESET    = '0;
   localparam logic [ADDR_W-1:0]   GPU_BASE_RESET    = '0;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_INIT  = 2'd2,
      MODE_NONE  = 2'd3
   } dia_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RSVD  = 2'd3
   } dia_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLOT_COUNT  = 2'd0,
      CSR_SLOT_STRIDE = 2'd1,
      CSR_CPU_BASE    = 2'd2,
      CSR_GPU_BASE    = 2'd3
   } dia_csr_type;

   typedef enum logic [1:0] {
      RSP_ZERO  = 2'd0,
      RSP_EMPTY = 2'd1,
      RSP_FULL  = 2'd2,
      RSP_ALLOC = 2'd3
   } dia_rsp_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ALLOC = 2'd1,
      ST_INIT  = 2'd2
   } dia_state_type;

   typedef struct packed {
      logic             alloc_issue;
      logic             alloc_finish;
      logic             free_push;
      logic             init_start;
      logic             init_step;
      logic             rsp_load;
      dia_rsp_kind_type rsp_kind;
   } dia_cmd_type;

   typedef struct packed {
      logic list_empty;
      logic list_full;
      logic init_none;
      logic init_last;
   } dia_stat_type;

endpackage

### rtl/dia_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dia_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/dia_ctrl.sv
// Controller state machine of the descriptor index allocator.
// Depends on dia_pkg; drives the datapath through dia_cmd_type.
module dia_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [dia_pkg::MODE_W-1:0] mode,
   input  dia_pkg::dia_stat_type stat,
   output logic                  busy,
   output dia_pkg::dia_cmd_type  cmd
);

   dia_pkg::dia_state_type state_ff;
   dia_pkg::dia_state_type state_in;
   dia_pkg::dia_mode_type  mode_code;

   assign mode_code = dia_pkg::dia_mode_type'(mode);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dia_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dia_pkg::ST_IDLE: begin
            if (start) begin
               if (mode_code == dia_pkg::MODE_ALLOC && !stat.list_empty) begin
                  state_in = dia_pkg::ST_ALLOC;
               end else if (mode_code == dia_pkg::MODE_INIT && !stat.init_none) begin
                  state_in = dia_pkg::ST_INIT;
               end
            end
         end
         dia_pkg::ST_ALLOC: begin
            state_in = dia_pkg::ST_IDLE;
         end
         dia_pkg::ST_INIT: begin
            if (stat.init_last) begin
               state_in = dia_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dia_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         dia_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (mode_code)
                  dia_pkg::MODE_ALLOC: begin
                     if (stat.list_empty) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_kind = dia_pkg::RSP_EMPTY;
                     end else begin
                        cmd.alloc_issue = 1'b1;
                     end
                  end
                  dia_pkg::MODE_FREE: begin
                     cmd.rsp_load = 1'b1;
                     if (stat.list_full) begin
                        cmd.rsp_kind = dia_pkg::RSP_FULL;
                     end else begin
                        cmd.free_push = 1'b1;
                        cmd.rsp_kind  = dia_pkg::RSP_ZERO;
                     end
                  end
                  dia_pkg::MODE_INIT: begin
                     cmd.init_start = 1'b1;
                     if (stat.init_none) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_kind = dia_pkg::RSP_ZERO;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = dia_pkg::RSP_ZERO;
                  end
               endcase
            end
         end
         dia_pkg::ST_ALLOC: begin
            cmd.alloc_finish = 1'b1;
            cmd.rsp_load     = 1'b1;
            cmd.rsp_kind     = dia_pkg::RSP_ALLOC;
         end
         dia_pkg::ST_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_last) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = dia_pkg::RSP_ZERO;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_issue |=> state_ff == dia_pkg::ST_ALLOC)
      else $error("alloc issue did not enter ALLOC");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == dia_pkg::ST_ALLOC |=> state_ff == dia_pkg::ST_IDLE)
      else $error("ALLOC lasted more than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.init_step && !stat.init_last) |=> state_ff == dia_pkg::ST_INIT)
      else $error("init walk left early");

endmodule

### rtl/dia_dpath.sv
// Datapath of the descriptor index allocator: config registers, list
// count, cached front entry, list RAM, address multiply-add and result
// registers. Depends on dia_pkg and dia_ram.
module dia_dpath #(
   parameter int SLOT_DEPTH = dia_pkg::SLOT_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [dia_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dia_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [dia_pkg::IDX_W-1:0]        freed_slot,
   input  dia_pkg::dia_cmd_type             cmd,
   output dia_pkg::dia_stat_type            stat,
   output logic                             rsp_valid,
   output logic [dia_pkg::STATUS_W-1:0]     rsp_status,
   output logic [dia_pkg::IDX_W-1:0]        rsp_slot_index,
   output logic [dia_pkg::ADDR_W-1:0]       rsp_cpu_address,
   output logic [dia_pkg::ADDR_W-1:0]       rsp_gpu_address
);

   localparam int AW    = $clog2(SLOT_DEPTH);
   localparam int CNT_W = $clog2(SLOT_DEPTH + 1);
   localparam int CMP_W = (CNT_W > dia_pkg::COUNT_W) ? CNT_W : dia_pkg::COUNT_W;

   logic [dia_pkg::COUNT_W-1:0]  slot_count_ff;
   logic [dia_pkg::STRIDE_W-1:0] slot_stride_ff;
   logic [dia_pkg::ADDR_W-1:0]   cpu_base_ff;
   logic [dia_pkg::ADDR_W-1:0]   gpu_base_ff;

   logic [CNT_W-1:0]             total_ff;
   logic [CNT_W-1:0]             total_in;
   logic [dia_pkg::IDX_W-1:0]    head_ff;
   logic [dia_pkg::IDX_W-1:0]    head_in;
   logic [AW-1:0]                walk_ff;
   logic [AW-1:0]                walk_in;
   logic [CNT_W-1:0]             limit_ff;
   logic [CNT_W-1:0]             limit_in;
   logic [dia_pkg::OFFSET_W-1:0] offset_ff;

   logic                         rsp_valid_ff;
   logic [dia_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [dia_pkg::STATUS_W-1:0] rsp_status_in;
   logic [dia_pkg::IDX_W-1:0]    rsp_index_ff;
   logic [dia_pkg::IDX_W-1:0]    rsp_index_in;
   logic [dia_pkg::ADDR_W-1:0]   rsp_cpu_ff;
   logic [dia_pkg::ADDR_W-1:0]   rsp_cpu_in;
   logic [dia_pkg::ADDR_W-1:0]   rsp_gpu_ff;
   logic [dia_pkg::ADDR_W-1:0]   rsp_gpu_in;

   logic [CMP_W-1:0]             count_wide;
   logic [CNT_W-1:0]             init_limit;
   logic [CNT_W-1:0]             tail_count;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [dia_pkg::IDX_W-1:0]    ram_wdata;
   logic [AW-1:0]                ram_raddr;
   logic [dia_pkg::IDX_W-1:0]    ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff  <= dia_pkg::SLOT_COUNT_RESET;
         slot_stride_ff <= dia_pkg::SLOT_STRIDE_RESET;
         cpu_base_ff    <= dia_pkg::CPU_BASE_RESET;
         gpu_base_ff    <= dia_pkg::GPU_BASE_RESET;
      end else if (csr_we) begin
         case (dia_pkg::dia_csr_type'(csr_index))
            dia_pkg::CSR_SLOT_COUNT:  slot_count_ff  <= csr_wdata[dia_pkg::COUNT_W-1:0];
            dia_pkg::CSR_SLOT_STRIDE: slot_stride_ff <= csr_wdata[dia_pkg::STRIDE_W-1:0];
            dia_pkg::CSR_CPU_BASE:    cpu_base_ff    <= csr_wdata;
            dia_pkg::CSR_GPU_BASE:    gpu_base_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign count_wide = CMP_W'(slot_count_ff);
   assign init_limit = (count_wide > CMP_W'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH)
                                                        : CNT_W'(count_wide);
   assign tail_count = total_ff - CNT_W'(1);

   assign stat.list_empty = (total_ff == '0);
   assign stat.list_full  = (total_ff == CNT_W'(SLOT_DEPTH));
   assign stat.init_none  = (init_limit == '0);
   assign stat.init_last  = ((CNT_W'(walk_ff) + CNT_W'(1)) == limit_ff);

   always_comb begin
      total_in  = total_ff;
      head_in   = head_ff;
      walk_in   = walk_ff;
      limit_in  = limit_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      if (cmd.free_push) begin
         ram_we    = 1'b1;
         ram_waddr = total_ff[AW-1:0];
         ram_wdata = freed_slot;
         total_in  = total_ff + CNT_W'(1);
         if (total_ff == '0) begin
            head_in = freed_slot;
         end
      end
      if (cmd.alloc_finish) begin
         ram_we    = 1'b1;
         ram_waddr = '0;
         ram_wdata = ram_rdata;
         head_in   = ram_rdata;
         total_in  = tail_count;
      end
      if (cmd.init_start) begin
         total_in = init_limit;
         limit_in = init_limit;
         head_in  = '0;
         walk_in  = '0;
      end
      if (cmd.init_step) begin
         ram_we    = 1'b1;
         ram_waddr = walk_ff;
         ram_wdata = dia_pkg::IDX_W'(walk_ff);
         walk_in   = walk_ff + AW'(1);
      end
   end

   assign ram_raddr = tail_count[AW-1:0];

   always_comb begin
      rsp_status_in = dia_pkg::STATUS_OK;
      rsp_index_in  = '0;
      rsp_cpu_in    = '0;
      rsp_gpu_in    = '0;
      case (cmd.rsp_kind)
         dia_pkg::RSP_EMPTY: begin
            rsp_status_in = dia_pkg::STATUS_EMPTY;
            rsp_index_in  = '1;
            rsp_cpu_in    = '1;
            rsp_gpu_in    = '1;
         end
         dia_pkg::RSP_FULL: begin
            rsp_status_in = dia_pkg::STATUS_FULL;
         end
         dia_pkg::RSP_ALLOC: begin
            rsp_index_in = head_ff;
            rsp_cpu_in   = cpu_base_ff + dia_pkg::ADDR_W'(offset_ff);
            rsp_gpu_in   = gpu_base_ff + dia_pkg::ADDR_W'(offset_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      walk_ff  <= walk_in;
      limit_ff <= limit_in;
      if (cmd.alloc_issue) begin
         offset_ff <= slot_stride_ff * head_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_cpu_ff    <= rsp_cpu_in;
         rsp_gpu_ff    <= rsp_gpu_in;
      end
   end

   dia_ram #(
      .WIDTH (dia_pkg::IDX_W),
      .DEPTH (SLOT_DEPTH)
   ) u_list_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_index_ff;
   assign rsp_cpu_address = rsp_cpu_ff;
   assign rsp_gpu_address = rsp_gpu_ff;

   assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(SLOT_DEPTH))
      else $error("list count above depth");

   assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_issue |-> !stat.list_empty)
      else $error("allocate issued on empty list");

   assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_finish |=> total_ff == $past(total_ff) - CNT_W'(1))
      else $error("allocate did not shrink the list");

endmodule

### rtl/descriptor_index_allocator.sv
// Top level of the descriptor index allocator: free list of slot indices.
// Depends on dia_pkg, dia_ctrl and dia_dpath (which holds dia_ram).
//
//  channel   ports                                       handshake
//  request   req_mode, req_freed_slot                    start && !busy
//  response  rsp_status, rsp_slot_index, rsp_*_address   rsp_valid, one cycle
//  config    csr_index, csr_wdata                        csr_we
//
// Free, allocate on empty list and unused mode: result registered in the cycle after accept.
// Allocate: passes through the ALLOC state for the registered tail read of the single list RAM read port.
// Init: walks min(slot_count, SLOT_DEPTH) entries (no walk when that is zero), one list
// write per cycle; busy stays high.
// Reset: list empty, registers at defaults; no RAM clearing pass.
// The receiver cannot stall; each transaction yields exactly one rsp_valid pulse.
module descriptor_index_allocator #(
   parameter int SLOT_DEPTH = dia_pkg::SLOT_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [dia_pkg::MODE_W-1:0]      req_mode,
   input  logic [dia_pkg::IDX_W-1:0]       req_freed_slot,
   output logic                            rsp_valid,
   output logic [dia_pkg::STATUS_W-1:0]    rsp_status,
   output logic [dia_pkg::IDX_W-1:0]       rsp_slot_index,
   output logic [dia_pkg::ADDR_W-1:0]      rsp_cpu_address,
   output logic [dia_pkg::ADDR_W-1:0]      rsp_gpu_address,
   input  logic                            csr_we,
   input  logic [dia_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dia_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dia_pkg::dia_cmd_type  cmd;
   dia_pkg::dia_stat_type stat;

   dia_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mode  (req_mode),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   dia_dpath #(
      .SLOT_DEPTH (SLOT_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .freed_slot      (req_freed_slot),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_cpu_address (rsp_cpu_address),
      .rsp_gpu_address (rsp_gpu_address)
   );

endmodule
